/* rtl/fbs_pkg.sv */
// Shared types and constants for the frame brightness statistics block.
package fbs_pkg;

    localparam int BYTES_PER_PIXEL = 3;
    localparam int PERCENT_FIXED   = 25600;

    localparam logic [7:0] BRIGHT_LEVEL = 8'd250;
    localparam logic [7:0] DARK_LEVEL   = 8'd25;

    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int BRIGHT_W  = 18;
    localparam int MEAN_W    = 8;
    localparam int COUNT_W   = 19;
    localparam int QUO_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_HALF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic              RST_UPPER_HALF   = 1'b1;
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] channel_two;
        logic [7:0] channel_one;
        logic [7:0] channel_zero;
    } fbs_pixel_t;

    typedef struct packed {
        logic              upper_half;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } fbs_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fbs_queue_status_t;

endpackage

/* rtl/frame_brightness_statistics_top.sv */
// Top level of the frame brightness statistics block.
//
// channel   | role   | transaction
// s_axis_*  | input  | one pixel, tuser = frame start
// m_axis_*  | output | one result per frame
// cfg_*     | input  | one register write
//
// Pixels are taken one per cycle; tready drops only when both queue entries hold
// frames the back end has not yet started.
// Per frame the back end steps through a load, 8 mean division steps, one multiply,
// one add, 17 score division steps and a result state; a frame with no samples goes from load to result.
// Asynchronous reset restores the register defaults and clears positions and totals.
// An unaccepted result holds in the output register; the next frame still streams in.
module frame_brightness_statistics_top #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_STEP = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // channel_zero, channel_one, channel_two
    input  logic                              s_axis_tuser,  // frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // brightness, mean_level, bright_saturated, dark_saturated, sample_count, zero pad
    output logic [87:0]                       m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbs_pkg::SIZE_W-1:0]        cfg_data
);
    import fbs_pkg::*;

    localparam longint CNT_MAX =
        longint'((MAX_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP) *
        longint'((MAX_HEIGHT + SAMPLE_STEP - 1) / SAMPLE_STEP);
    localparam int CNT_W = $clog2(CNT_MAX + 1);
    localparam int SUM_W = $clog2(CNT_MAX * BYTES_PER_PIXEL * 255 + 1);
    localparam int JOB_W = SUM_W + 3 * CNT_W;
    localparam int OUT_BITS = BRIGHT_W + MEAN_W + 3 * COUNT_W;

    fbs_cfg_t          cfg_reg, cfg_next;
    fbs_pixel_t        pixel;
    fbs_queue_status_t q_status;

    logic              push, pop;
    logic [SUM_W-1:0]  f_sum, b_sum;
    logic [CNT_W-1:0]  f_count, f_bright, f_dark;
    logic [CNT_W-1:0]  b_count, b_bright, b_dark;
    logic [JOB_W-1:0]  push_data, pop_data;

    logic signed [BRIGHT_W-1:0] brightness;
    logic [MEAN_W-1:0]          mean_level;
    logic [COUNT_W-1:0]         bright_saturated, dark_saturated, sample_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_UPPER_HALF:   cfg_next.upper_half   = cfg_data[0];
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data;
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.upper_half   <= RST_UPPER_HALF;
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pixel.channel_zero = s_axis_tdata[7:0];
    assign pixel.channel_one  = s_axis_tdata[15:8];
    assign pixel.channel_two  = s_axis_tdata[23:16];
    assign pixel.frame_start  = s_axis_tuser;

    fbs_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_STEP (SAMPLE_STEP),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (s_axis_tvalid),
        .pixel_ready (s_axis_tready),
        .pixel       (pixel),
        .q_status    (q_status),
        .push        (push),
        .job_sum     (f_sum),
        .job_count   (f_count),
        .job_bright  (f_bright),
        .job_dark    (f_dark)
    );

    assign push_data = {f_sum, f_count, f_bright, f_dark};
    assign {b_sum, b_count, b_bright, b_dark} = pop_data;

    fbs_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    fbs_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .pop              (pop),
        .job_sum          (b_sum),
        .job_count        (b_count),
        .job_bright       (b_bright),
        .job_dark         (b_dark),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .brightness       (brightness),
        .mean_level       (mean_level),
        .bright_saturated (bright_saturated),
        .dark_saturated   (dark_saturated),
        .sample_count     (sample_count)
    );

    assign m_axis_tdata = {{(88 - OUT_BITS){1'b0}}, sample_count, dark_saturated,
                           bright_saturated, mean_level, brightness};

endmodule

/* rtl/fbs_queue.sv */
// Two-entry queue carrying finished frame totals from front to back.
module fbs_queue #(
    parameter int WIDTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output fbs_pkg::fbs_queue_status_t   status
);
    import fbs_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from empty queue");
`endif

endmodule

/* rtl/fbs_front.sv */
// Pixel front end: position tracking, sample selection and frame totals.
module fbs_front #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_STEP = 5,
    parameter int CNT_W       = 19,
    parameter int SUM_W       = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fbs_pkg::fbs_cfg_t            cfg,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  fbs_pkg::fbs_pixel_t          pixel,
    input  fbs_pkg::fbs_queue_status_t   q_status,
    output logic                         push,
    output logic [SUM_W-1:0]             job_sum,
    output logic [CNT_W-1:0]             job_count,
    output logic [CNT_W-1:0]             job_bright,
    output logic [CNT_W-1:0]             job_dark
);
    import fbs_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PH_W  = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam int SH    = HW + PH_W;
    localparam int PW    = HW + SH + 1;
    localparam longint RECIP = ((longint'(1) << SH) + SAMPLE_STEP - 1) / SAMPLE_STEP;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(SAMPLE_STEP - 1);

    logic [COL_W-1:0] col_reg, col_next, col_e;
    logic [ROW_W-1:0] row_reg, row_next, row_e;
    logic [PH_W-1:0]  colph_reg, colph_next, colph_e;
    logic [PH_W-1:0]  rowph_reg, rowph_next, rowph_e;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_e, sum_new;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_e, cnt_new;
    logic [CNT_W-1:0] brt_reg, brt_next, brt_e, brt_new;
    logic [CNT_W-1:0] drk_reg, drk_next, drk_e, drk_new;

    logic [WW-1:0]   w;
    logic [HW-1:0]   h;
    logic [HW-1:0]   half;
    logic [HW-1:0]   base;
    logic [PW-1:0]   base_prod;
    logic [HW-1:0]   base_quo;
    logic [HW-1:0]   base_rem;
    logic [PH_W-1:0] base_mod;
    logic [HW-1:0]   row_w;
    logic [9:0]      pix_sum;
    logic            fs, accept, col_ok, row_ok, sample, is_bright, is_dark;
    logic            end_row, end_frame;

    always_comb
    begin
        if (cfg.frame_width == '0)
        begin
            w = WW'(1);
        end
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(cfg.frame_width);
        end

        if (cfg.frame_height == '0)
        begin
            h = HW'(1);
        end
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
        begin
            h = HW'(MAX_HEIGHT);
        end
        else
        begin
            h = HW'(cfg.frame_height);
        end
    end

    assign half = h >> 1;
    assign base = cfg.upper_half ? '0 : half;

    // base modulo the sample step, by reciprocal multiplication
    assign base_prod = PW'(base) * PW'(RECIP);
    assign base_quo  = HW'(base_prod >> SH);
    assign base_rem  = base - HW'(base_quo * HW'(SAMPLE_STEP));
    assign base_mod  = PH_W'(base_rem);

    assign fs      = pixel.frame_start;
    assign col_e   = fs ? '0 : col_reg;
    assign row_e   = fs ? '0 : row_reg;
    assign colph_e = fs ? '0 : colph_reg;
    assign rowph_e = fs ? '0 : rowph_reg;
    assign sum_e   = fs ? '0 : sum_reg;
    assign cnt_e   = fs ? '0 : cnt_reg;
    assign brt_e   = fs ? '0 : brt_reg;
    assign drk_e   = fs ? '0 : drk_reg;

    assign row_w  = HW'(row_e);
    assign col_ok = (WW'(col_e) < w) && (colph_e == '0);
    assign row_ok = (row_w >= base) && (row_w < base + half) && (rowph_e == base_mod);
    assign sample = col_ok && row_ok;

    assign pix_sum   = 10'(pixel.channel_zero) + 10'(pixel.channel_one)
                     + 10'(pixel.channel_two);
    assign is_bright = (pixel.channel_zero >= BRIGHT_LEVEL) && (pixel.channel_one >= BRIGHT_LEVEL)
                     && (pixel.channel_two >= BRIGHT_LEVEL);
    assign is_dark   = (pixel.channel_zero <= DARK_LEVEL) && (pixel.channel_one <= DARK_LEVEL)
                     && (pixel.channel_two <= DARK_LEVEL);

    assign sum_new = sum_e + (sample ? SUM_W'(pix_sum) : '0);
    assign cnt_new = cnt_e + CNT_W'(sample);
    assign brt_new = brt_e + CNT_W'(sample && is_bright);
    assign drk_new = drk_e + CNT_W'(sample && is_dark);

    assign end_row   = (WW'(col_e) + WW'(1)) >= w;
    assign end_frame = end_row && ((row_w + HW'(1)) >= h);

    assign pixel_ready = !q_status.full;
    assign accept      = pixel_valid && pixel_ready;
    assign push        = accept && end_frame;
    assign job_sum     = sum_new;
    assign job_count   = cnt_new;
    assign job_bright  = brt_new;
    assign job_dark    = drk_new;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        colph_next = colph_reg;
        rowph_next = rowph_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        brt_next   = brt_reg;
        drk_next   = drk_reg;
        if (accept)
        begin
            row_next   = row_e;
            rowph_next = rowph_e;
            sum_next   = sum_new;
            cnt_next   = cnt_new;
            brt_next   = brt_new;
            drk_next   = drk_new;
            if (end_row)
            begin
                col_next   = '0;
                colph_next = '0;
                if (end_frame)
                begin
                    row_next   = '0;
                    rowph_next = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    brt_next   = '0;
                    drk_next   = '0;
                end
                else
                begin
                    row_next   = row_e + ROW_W'(1);
                    rowph_next = (rowph_e == PH_LAST) ? '0 : rowph_e + PH_W'(1);
                end
            end
            else
            begin
                col_next   = col_e + COL_W'(1);
                colph_next = (colph_e == PH_LAST) ? '0 : colph_e + PH_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            colph_reg <= '0;
            rowph_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            brt_reg   <= '0;
            drk_reg   <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            colph_reg <= colph_next;
            rowph_reg <= rowph_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            brt_reg   <= brt_next;
            drk_reg   <= drk_next;
        end
    end

endmodule

/* rtl/fbs_back.sv */
// Back end: mean and score from frame totals through a shared serial divider.
module fbs_back #(
    parameter int CNT_W = 19,
    parameter int SUM_W = 28
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fbs_pkg::fbs_queue_status_t          q_status,
    output logic                                pop,
    input  logic [SUM_W-1:0]                    job_sum,
    input  logic [CNT_W-1:0]                    job_count,
    input  logic [CNT_W-1:0]                    job_bright,
    input  logic [CNT_W-1:0]                    job_dark,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fbs_pkg::BRIGHT_W-1:0] brightness,
    output logic [fbs_pkg::MEAN_W-1:0]          mean_level,
    output logic [fbs_pkg::COUNT_W-1:0]         bright_saturated,
    output logic [fbs_pkg::COUNT_W-1:0]         dark_saturated,
    output logic [fbs_pkg::COUNT_W-1:0]         sample_count
);
    import fbs_pkg::*;

    localparam int NUM_W = CNT_W + QUO_W + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DIV_W = (SUM_W > MAG_W) ? SUM_W : MAG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV1 = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        den_reg, den_next;
    logic [QUO_W-1:0]        q_reg, q_next;
    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        b_reg, b_next;
    logic [CNT_W-1:0]        d_reg, d_next;
    logic signed [NUM_W-1:0] pa_reg, pa_next;
    logic signed [NUM_W-1:0] pb_reg, pb_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [BRIGHT_W-1:0] bri_reg, bri_next;
    logic [MEAN_W-1:0]       om_reg, om_next;
    logic [COUNT_W-1:0]      ob_reg, ob_next;
    logic [COUNT_W-1:0]      od_reg, od_next;
    logic [COUNT_W-1:0]      on_reg, on_next;

    logic                    ge;
    logic [DIV_W-1:0]        sub;
    logic signed [CNT_W:0]   diff;
    logic signed [NUM_W-1:0] num;
    logic [BRIGHT_W-1:0]     q_ext;
    logic                    load_out;

    assign ge   = rem_reg >= den_reg;
    assign sub  = rem_reg - den_reg;
    assign diff = $signed({1'b0, b_reg}) - $signed({1'b0, d_reg});
    assign num  = pa_reg + pb_reg;
    assign q_ext = BRIGHT_W'(q_reg);

    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        mean_next  = mean_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    n_next    = job_count;
                    b_next    = job_bright;
                    d_next    = job_dark;
                    rem_next  = DIV_W'(job_sum);
                    den_next  = (DIV_W'(job_count) * DIV_W'(BYTES_PER_PIXEL)) << (MEAN_W - 1);
                    cnt_next  = 5'(MEAN_W - 1);
                    q_next    = '0;
                    mean_next = '0;
                    neg_next  = 1'b0;
                    state_next = (job_count == '0) ? ST_FIN : ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                rem_next = ge ? sub : rem_reg;
                den_next = den_reg >> 1;
                q_next   = {q_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == ST_DIV1)
                    begin
                        mean_next  = q_next[MEAN_W-1:0];
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL:
            begin
                pa_next = $signed((NUM_W'(mean_reg) * NUM_W'(n_reg)) << 8);
                pb_next = NUM_W'(diff) * $signed(NUM_W'(PERCENT_FIXED));
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                neg_next = num[NUM_W-1];
                rem_next = DIV_W'(MAG_W'(num[NUM_W-1] ? -num : num));
                den_next = DIV_W'(n_reg) << (QUO_W - 1);
                cnt_next = 5'(QUO_W - 1);
                q_next   = '0;
                state_next = ST_DIV2;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        bri_next = bri_reg;
        om_next  = om_reg;
        ob_next  = ob_reg;
        od_next  = od_reg;
        on_next  = on_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            bri_next = $signed(neg_reg ? (~q_ext + BRIGHT_W'(1)) : q_ext);
            om_next  = mean_reg;
            ob_next  = COUNT_W'(b_reg);
            od_next  = COUNT_W'(d_reg);
            on_next  = COUNT_W'(n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        mean_reg <= mean_next;
        neg_reg  <= neg_next;
        n_reg    <= n_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        bri_reg  <= bri_next;
        om_reg   <= om_next;
        ob_reg   <= ob_next;
        od_reg   <= od_next;
        on_reg   <= on_next;
    end

    assign out_valid        = out_valid_reg;
    assign brightness       = bri_reg;
    assign mean_level       = om_reg;
    assign bright_saturated = ob_reg;
    assign dark_saturated   = od_reg;
    assign sample_count     = on_reg;

`ifndef SYNTHESIS
    a_mean_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (rem_reg < DIV_W'(n_reg) * DIV_W'(BYTES_PER_PIXEL)))
        else $error("mean division remainder not below divisor");
    a_score_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && $past(state_reg) == ST_DIV2) |-> (rem_reg < DIV_W'(n_reg)))
        else $error("score division remainder not below divisor");
    a_neg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && neg_reg) |-> (q_reg <= QUO_W'(PERCENT_FIXED)))
        else $error("negative score beyond range");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1) |-> (cnt_reg < 5'(MEAN_W)))
        else $error("mean division step count out of range");
`endif

endmodule

/* verif/tb_frame_brightness_statistics_top.sv */
// Self-checking testbench for frame_brightness_statistics_top: directed and random frames.
`timescale 1ns / 1ps

module tb_frame_brightness_statistics_top;
    import fbs_pkg::*;

    localparam int SAMPLE_STEP = 5;
    localparam int MAX_SIZE    = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [MEAN_W-1:0]   mean_level;
        logic [COUNT_W-1:0]  bright_saturated;
        logic [COUNT_W-1:0]  dark_saturated;
        logic [COUNT_W-1:0]  sample_count;
    } frame_stats_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [87:0]          m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // shadow registers and running totals
    logic                 upper_q  = RST_UPPER_HALF;
    logic [SIZE_W-1:0]    width_q  = RST_FRAME_WIDTH;
    logic [SIZE_W-1:0]    height_q = RST_FRAME_HEIGHT;
    int                   col_pos = 0;
    int                   row_pos = 0;
    longint               level_total = 0;
    longint               samples = 0;
    longint               bright_total = 0;
    longint               dark_total = 0;

    frame_stats_t         stats_due[$];
    int                   mismatches = 0;
    int                   pixels_sent = 0;
    bit                   no_idle = 1'b0;

    frame_brightness_statistics_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_size(input logic [SIZE_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return int'(v);
    endfunction

    function automatic void clear_totals();
        level_total  = 0;
        samples      = 0;
        bright_total = 0;
        dark_total   = 0;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input int lo);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return SIZE_W'($urandom_range(9, 24));
            default: return SIZE_W'($urandom_range(lo, 8));
        endcase
    endfunction

    function automatic logic [23:0] pick_pixel();
        int          mode;
        logic [23:0] px;
        mode = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++)
            case (mode)
                0:       px[8*i +: 8] = 8'($urandom_range(250, 255));
                1:       px[8*i +: 8] = 8'($urandom_range(0, 25));
                2:       px[8*i +: 8] = $urandom_range(0, 1) ? 8'($urandom_range(24, 26))
                                                             : 8'($urandom_range(249, 251));
                default: px[8*i +: 8] = 8'($urandom);
            endcase
        return px;
    endfunction

    task automatic track_pixel(input logic [23:0] px, input logic fs);
        int           w;
        int           h;
        int           half;
        int           base;
        logic [7:0]   c0;
        logic [7:0]   c1;
        logic [7:0]   c2;
        bit           row_ok;
        bit           col_ok;
        longint       mean;
        longint       num;
        frame_stats_t r;
        c0   = px[7:0];
        c1   = px[15:8];
        c2   = px[23:16];
        w    = clamp_size(width_q);
        h    = clamp_size(height_q);
        half = h / 2;
        base = upper_q ? 0 : half;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
            clear_totals();
        end
        row_ok = row_pos >= base && row_pos < base + half && (row_pos - base) % SAMPLE_STEP == 0;
        col_ok = col_pos < w && col_pos % SAMPLE_STEP == 0;
        if (row_ok && col_ok)
        begin
            level_total += longint'(c0) + longint'(c1) + longint'(c2);
            samples++;
            if (c0 >= BRIGHT_LEVEL && c1 >= BRIGHT_LEVEL && c2 >= BRIGHT_LEVEL)
                bright_total++;
            if (c0 <= DARK_LEVEL && c1 <= DARK_LEVEL && c2 <= DARK_LEVEL)
                dark_total++;
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                r = '0;
                if (samples != 0)
                begin
                    mean = level_total / (BYTES_PER_PIXEL * samples);
                    num  = mean * 256 * samples + (bright_total - dark_total) * PERCENT_FIXED;
                    r.brightness = BRIGHT_W'(num / samples);
                    r.mean_level = MEAN_W'(mean);
                end
                r.bright_saturated = COUNT_W'(bright_total);
                r.dark_saturated   = COUNT_W'(dark_total);
                r.sample_count     = COUNT_W'(samples);
                stats_due.push_back(r);
                row_pos = 0;
                clear_totals();
            end
            else
                row_pos++;
        end
        else
            col_pos++;
    endtask

    task automatic send_pixel(input logic [23:0] px, input logic fs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= px;
        s_axis_tuser  <= fs;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_pixel(px, fs);
        pixels_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(), i == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_UPPER_HALF:   upper_q  = val[0];
            CFG_FRAME_WIDTH:  width_q  = val;
            CFG_FRAME_HEIGHT: height_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain results, then leave room for the back end to go quiet
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic test_saturation_levels();
        logic [23:0] probe[6];
        probe = '{24'hFFFFFF, 24'h000000, 24'hFAFAFA, 24'h191919, 24'hF9FAFA, 24'h1A1919};
        settle();
        write_reg(CFG_UPPER_HALF, SIZE_W'(1));
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(1));
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(2));
        foreach (probe[i])
        begin
            send_pixel(probe[i], 1'b1);
            send_pixel(pick_pixel(), 1'b0);
        end
    endtask

    task automatic test_lower_half();
        settle();
        write_reg(CFG_UPPER_HALF, 13'h1FFE);
        write_reg(CFG_SPARE, 13'h1FFF);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_frame(2);
    endtask

    task automatic test_no_samples();
        settle();
        write_reg(CFG_FRAME_HEIGHT, '0);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b0);
    endtask

    task automatic test_size_shrink();
        settle();
        write_reg(CFG_UPPER_HALF, SIZE_W'(1));
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(4));
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(4));
        send_frame(6);
        settle();
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(2));
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(2));
        send_pixel(pick_pixel(), 1'b0);
    endtask

    task automatic test_random_frames();
        int len;
        int full;
        while (pixels_sent < 800)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                write_reg(CFG_UPPER_HALF, SIZE_W'($urandom));
                write_reg(CFG_FRAME_WIDTH, pick_size(1));
                write_reg(CFG_FRAME_HEIGHT, pick_size(2));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            full = clamp_size(width_q) * clamp_size(height_q);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, full) : full;
            for (int i = 0; i < len; i++)
                send_pixel(pick_pixel(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                                  : ($urandom_range(0, 199) == 0));
        end
        no_idle = 1'b0;
    endtask

    // oversized and zero registers, each followed by a shrink to close the frame early
    task automatic test_extreme_sizes();
        settle();
        write_reg(CFG_UPPER_HALF, SIZE_W'(1));
        write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(2));
        send_frame(24);
        settle();
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(2));
        repeat (3) send_pixel(pick_pixel(), 1'b0);
        settle();
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        send_frame(20);
        settle();
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(2));
        send_pixel(pick_pixel(), 1'b0);
    endtask

    initial
    begin : result_sink
        int           stall;
        frame_stats_t want;
        frame_stats_t got;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.brightness       = m_axis_tdata[17:0];
            got.mean_level       = m_axis_tdata[25:18];
            got.bright_saturated = m_axis_tdata[44:26];
            got.dark_saturated   = m_axis_tdata[63:45];
            got.sample_count     = m_axis_tdata[82:64];
            if (stats_due.size() == 0)
            begin
                $error("result transaction with no frame outstanding");
                mismatches++;
            end
            else
            begin
                want = stats_due.pop_front();
                check_field("brightness", $signed(want.brightness), $signed(got.brightness));
                check_field("mean_level", want.mean_level, got.mean_level);
                check_field("bright_saturated", want.bright_saturated, got.bright_saturated);
                check_field("dark_saturated", want.dark_saturated, got.dark_saturated);
                check_field("sample_count", want.sample_count, got.sample_count);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_saturation_levels();
        test_lower_half();
        test_no_samples();
        test_size_shrink();
        test_random_frames();
        test_extreme_sizes();
        settle();
        if (mismatches == 0)
            $display("tb_frame_brightness_statistics_top: clean");
        else
            $display("tb_frame_brightness_statistics_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_frame_brightness_statistics_top: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/fbs_pkg.sv
rtl/fbs_queue.sv
rtl/fbs_front.sv
rtl/fbs_back.sv
rtl/frame_brightness_statistics_top.sv
verif/tb_frame_brightness_statistics_top.sv
